>>> src/psc_pkg.sv
// package with item types and decode constants for the pulse and sawtooth tone generator
`timescale 1ns / 1ps

package psc_pkg;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_WRITE = 1'b1
  } psc_mode_e;

  typedef enum logic [1:0] {
    REG_CTRL  = 2'd0,
    REG_PER_LO = 2'd1,
    REG_PER_HI = 2'd2,
    REG_NONE  = 2'd3
  } psc_reg_e;

  localparam logic [15:0] PULSE1_BASE = 16'h9000;
  localparam logic [15:0] PULSE2_BASE = 16'hA000;
  localparam logic [15:0] SAW_BASE    = 16'hB000;

  localparam int unsigned NUM_PULSE = 2;
  localparam logic [3:0] SAW_PHASES = 4'd14;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } psc_in_t;

  typedef struct packed {
    logic [3:0] pulse1_level;
    logic [3:0] pulse2_level;
    logic [4:0] saw_level;
  } psc_out_t;

  // one divider tick: step flag in the top bit, next divider value below
  function automatic logic [13:0] div_tick(input logic [12:0] div, input logic [11:0] period);
    logic [13:0] res;
    if (div == 13'd0) begin
      res = {1'b1, 1'b0, period};
    end else if (div == 13'd1) begin
      res = {1'b1, {1'b0, period} + 13'd1};
    end else begin
      res = {1'b0, div - 13'd1};
    end
    return res;
  endfunction

endpackage

>>> src/pulse_sawtooth_sound_channels.sv
// top level of the two pulse and one sawtooth tone generator
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o   | psc_in_t  (mode, address, write_data)
//   out     | output    | out_valid_o / out_ready_i | psc_out_t (three levels)
//
// one item per cycle: write decode and voice update sit between the voice
// registers and a result register, one item enters every cycle while in_ready_o is high
// a skid register behind the result register keeps in_ready_o high for one
// item while the output is stalled; in_ready_o drops only when both are full
// reset clears all voice state and the valid flags of both result stages
`timescale 1ns / 1ps

module pulse_sawtooth_sound_channels (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  psc_pkg::psc_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output psc_pkg::psc_out_t out_o
);
  import psc_pkg::*;

  // voice state
  logic        pulse_gate_q   [NUM_PULSE];
  logic [3:0]  pulse_duty_q   [NUM_PULSE];
  logic [3:0]  pulse_vol_q    [NUM_PULSE];
  logic        pulse_en_q     [NUM_PULSE];
  logic [11:0] pulse_period_q [NUM_PULSE];
  logic [12:0] pulse_div_q    [NUM_PULSE];
  logic [3:0]  pulse_step_q   [NUM_PULSE];
  logic [3:0]  pulse_out_q    [NUM_PULSE];
  logic        pulse_gate_d   [NUM_PULSE];
  logic [3:0]  pulse_duty_d   [NUM_PULSE];
  logic [3:0]  pulse_vol_d    [NUM_PULSE];
  logic        pulse_en_d     [NUM_PULSE];
  logic [11:0] pulse_period_d [NUM_PULSE];
  logic [12:0] pulse_div_d    [NUM_PULSE];
  logic [3:0]  pulse_step_d   [NUM_PULSE];
  logic [3:0]  pulse_out_d    [NUM_PULSE];

  logic [5:0]  saw_rate_q, saw_rate_d;
  logic        saw_en_q, saw_en_d;
  logic [11:0] saw_period_q, saw_period_d;
  logic [12:0] saw_div_q, saw_div_d;
  logic [7:0]  saw_accum_q, saw_accum_d;
  logic [3:0]  saw_phase_q, saw_phase_d;
  logic [4:0]  saw_out_q, saw_out_d;

  // result stages
  logic     out_vld_q, skid_vld_q;
  psc_out_t out_q, skid_q, res;

  logic     accept, out_free;
  logic     is_write;
  logic [1:0] reg_sel;
  logic     sel_pulse [NUM_PULSE];
  logic     sel_saw;
  logic [13:0] ptick [NUM_PULSE];
  logic [13:0] stick;
  logic [3:0]  step_nx [NUM_PULSE];
  logic [3:0]  phase_nx;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_vld_q || out_ready_i;
  assign in_ready_o  = !skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  assign is_write     = (in_i.mode == MODE_WRITE);
  assign reg_sel      = in_i.address[1:0];
  assign sel_pulse[0] = (in_i.address[15:2] == PULSE1_BASE[15:2]);
  assign sel_pulse[1] = (in_i.address[15:2] == PULSE2_BASE[15:2]);
  assign sel_saw      = (in_i.address[15:2] == SAW_BASE[15:2]);

  always_comb begin
    for (int v = 0; v < NUM_PULSE; v++) begin
      pulse_gate_d[v]   = pulse_gate_q[v];
      pulse_duty_d[v]   = pulse_duty_q[v];
      pulse_vol_d[v]    = pulse_vol_q[v];
      pulse_en_d[v]     = pulse_en_q[v];
      pulse_period_d[v] = pulse_period_q[v];
      pulse_div_d[v]    = pulse_div_q[v];
      pulse_step_d[v]   = pulse_step_q[v];
      pulse_out_d[v]    = pulse_out_q[v];
      ptick[v]          = div_tick(pulse_div_q[v], pulse_period_q[v]);
      step_nx[v]        = pulse_step_q[v] + 4'd1;
      if (is_write) begin
        if (sel_pulse[v]) begin
          case (reg_sel)
            REG_CTRL: begin
              pulse_gate_d[v] = in_i.write_data[7];
              pulse_duty_d[v] = {1'b0, in_i.write_data[6:4]} + 4'd1;
              pulse_vol_d[v]  = in_i.write_data[3:0];
              if (in_i.write_data[7]) begin
                pulse_out_d[v] = in_i.write_data[3:0];
              end
            end
            REG_PER_LO: pulse_period_d[v][7:0] = in_i.write_data;
            REG_PER_HI: begin
              pulse_en_d[v]          = in_i.write_data[7];
              pulse_period_d[v][11:8] = in_i.write_data[3:0];
            end
            default: ;
          endcase
        end
      end else if (pulse_en_q[v] && (pulse_period_q[v] != 12'd0)) begin
        pulse_div_d[v] = ptick[v][12:0];
        if (ptick[v][13]) begin
          pulse_step_d[v] = step_nx[v];
          pulse_out_d[v]  = (pulse_gate_q[v] || (step_nx[v] >= pulse_duty_q[v]))
                            ? pulse_vol_q[v] : 4'd0;
        end
      end
    end
  end

  always_comb begin
    saw_rate_d   = saw_rate_q;
    saw_en_d     = saw_en_q;
    saw_period_d = saw_period_q;
    saw_div_d    = saw_div_q;
    saw_accum_d  = saw_accum_q;
    saw_phase_d  = saw_phase_q;
    saw_out_d    = saw_out_q;
    stick        = div_tick(saw_div_q, saw_period_q);
    phase_nx     = saw_phase_q + 4'd1;
    if (is_write) begin
      if (sel_saw) begin
        case (reg_sel)
          REG_CTRL:   saw_rate_d = in_i.write_data[5:0];
          REG_PER_LO: saw_period_d[7:0] = in_i.write_data;
          REG_PER_HI: begin
            saw_en_d           = in_i.write_data[7];
            saw_period_d[11:8] = in_i.write_data[3:0];
          end
          default: ;
        endcase
      end
    end else if (saw_en_q && (saw_period_q != 12'd0)) begin
      saw_div_d = stick[12:0];
      if (stick[13]) begin
        if (phase_nx >= SAW_PHASES) begin
          saw_accum_d = 8'd0;
          saw_phase_d = 4'd0;
        end else begin
          saw_phase_d = phase_nx;
          if (saw_phase_q[0]) begin
            saw_accum_d = saw_accum_q + {2'b00, saw_rate_q};
          end
        end
        saw_out_d = (phase_nx >= SAW_PHASES) ? 5'd0
                  : (saw_phase_q[0] ? saw_accum_d[7:3] : saw_accum_q[7:3]);
      end
    end
  end

  always_comb begin
    res.pulse1_level = pulse_out_d[0];
    res.pulse2_level = pulse_out_d[1];
    res.saw_level    = saw_out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_PULSE; v++) begin
        pulse_gate_q[v]   <= 1'b0;
        pulse_duty_q[v]   <= 4'd0;
        pulse_vol_q[v]    <= 4'd0;
        pulse_en_q[v]     <= 1'b0;
        pulse_period_q[v] <= 12'd0;
        pulse_div_q[v]    <= 13'd0;
        pulse_step_q[v]   <= 4'd0;
        pulse_out_q[v]    <= 4'd0;
      end
      saw_rate_q   <= 6'd0;
      saw_en_q     <= 1'b0;
      saw_period_q <= 12'd0;
      saw_div_q    <= 13'd0;
      saw_accum_q  <= 8'd0;
      saw_phase_q  <= 4'd0;
      saw_out_q    <= 5'd0;
    end else if (accept) begin
      for (int v = 0; v < NUM_PULSE; v++) begin
        pulse_gate_q[v]   <= pulse_gate_d[v];
        pulse_duty_q[v]   <= pulse_duty_d[v];
        pulse_vol_q[v]    <= pulse_vol_d[v];
        pulse_en_q[v]     <= pulse_en_d[v];
        pulse_period_q[v] <= pulse_period_d[v];
        pulse_div_q[v]    <= pulse_div_d[v];
        pulse_step_q[v]   <= pulse_step_d[v];
        pulse_out_q[v]    <= pulse_out_d[v];
      end
      saw_rate_q   <= saw_rate_d;
      saw_en_q     <= saw_en_d;
      saw_period_q <= saw_period_d;
      saw_div_q    <= saw_div_d;
      saw_accum_q  <= saw_accum_d;
      saw_phase_q  <= saw_phase_d;
      saw_out_q    <= saw_out_d;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= accept;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= res;
        end
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage full while result register empty");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saw_phase_q < SAW_PHASES)
    else $error("sawtooth phase count out of range");

  a_write_holds_saw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_write) |=> $stable(saw_out_q) && $stable(saw_div_q))
    else $error("write item moved sawtooth voice");

  a_idle_pulse_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_write && !pulse_en_q[0]) |=> $stable(pulse_div_q[0]))
    else $error("disabled pulse divider moved");

endmodule

>>> tb/sv/testbench.sv
// testbench for the pulse and sawtooth tone generator: scoreboard predictor, directed and random items
`timescale 1ns / 1ps

module testbench;
  import psc_pkg::*;

  localparam int N_ITEMS      = 1850;
  localparam int CALM_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 400;

  class tone_scoreboard;
    logic        pulse_gate  [NUM_PULSE];
    logic [3:0]  pulse_duty  [NUM_PULSE];
    logic [3:0]  pulse_vol   [NUM_PULSE];
    logic        pulse_on    [NUM_PULSE];
    logic [11:0] pulse_period[NUM_PULSE];
    logic [12:0] pulse_div   [NUM_PULSE];
    logic [3:0]  pulse_count [NUM_PULSE];
    logic [3:0]  pulse_lvl   [NUM_PULSE];
    logic [5:0]  saw_rate;
    logic        saw_on;
    logic [11:0] saw_period;
    logic [12:0] saw_div;
    logic [7:0]  saw_accum;
    logic [3:0]  saw_phase;
    logic [4:0]  saw_lvl;
    psc_out_t    expected_levels[$];
    int          mismatches;

    function new();
      for (int v = 0; v < NUM_PULSE; v++) begin
        pulse_gate[v]   = 1'b0;
        pulse_duty[v]   = '0;
        pulse_vol[v]    = '0;
        pulse_on[v]     = 1'b0;
        pulse_period[v] = '0;
        pulse_div[v]    = '0;
        pulse_count[v]  = '0;
        pulse_lvl[v]    = '0;
      end
      saw_rate    = '0;
      saw_on      = 1'b0;
      saw_period  = '0;
      saw_div     = '0;
      saw_accum   = '0;
      saw_phase   = '0;
      saw_lvl     = '0;
      mismatches  = 0;
    endfunction

    function bit divider_fires(input logic [12:0] count, input logic [11:0] period,
                               output logic [12:0] next_count);
      bit fires;
      fires = 1'b1;
      if (count == 13'd0) begin
        next_count = {1'b0, period};
      end else if (count == 13'd1) begin
        next_count = {1'b0, period} + 13'd1;
      end else begin
        next_count = count - 13'd1;
        fires = 1'b0;
      end
      return fires;
    endfunction

    function void tick_pulse(int v);
      logic [12:0] nxt;
      if (pulse_on[v] && pulse_period[v] != 12'd0) begin
        if (divider_fires(pulse_div[v], pulse_period[v], nxt)) begin
          pulse_count[v] = pulse_count[v] + 4'd1;
          pulse_lvl[v] = (pulse_gate[v] || pulse_count[v] >= pulse_duty[v]) ? pulse_vol[v] : 4'd0;
        end
        pulse_div[v] = nxt;
      end
    endfunction

    function void tick_saw();
      logic [12:0] nxt;
      if (saw_on && saw_period != 12'd0) begin
        if (divider_fires(saw_div, saw_period, nxt)) begin
          if (saw_phase[0]) begin
            saw_accum = saw_accum + {2'b00, saw_rate};
          end
          saw_phase = saw_phase + 4'd1;
          if (saw_phase >= SAW_PHASES) begin
            saw_accum = '0;
            saw_phase = '0;
          end
          saw_lvl = saw_accum[7:3];
        end
        saw_div = nxt;
      end
    endfunction

    function void write_pulse(int v, psc_reg_e r, logic [7:0] d);
      case (r)
        REG_CTRL: begin
          pulse_gate[v] = d[7];
          pulse_duty[v] = {1'b0, d[6:4]} + 4'd1;
          pulse_vol[v]  = d[3:0];
          if (d[7]) begin
            pulse_lvl[v] = d[3:0];
          end
        end
        REG_PER_LO: pulse_period[v][7:0] = d;
        REG_PER_HI: begin
          pulse_on[v] = d[7];
          pulse_period[v][11:8] = d[3:0];
        end
        default: ;
      endcase
    endfunction

    function void write_saw(psc_reg_e r, logic [7:0] d);
      case (r)
        REG_CTRL:   saw_rate = d[5:0];
        REG_PER_LO: saw_period[7:0] = d;
        REG_PER_HI: begin
          saw_on = d[7];
          saw_period[11:8] = d[3:0];
        end
        default: ;
      endcase
    endfunction

    function void note_item(psc_in_t item);
      logic [15:0] base;
      psc_reg_e    r;
      psc_out_t    lv;
      base = item.address & 16'hFFFC;
      r = psc_reg_e'(item.address[1:0]);
      if (item.mode == MODE_WRITE) begin
        if (r != REG_NONE) begin
          if (base == PULSE1_BASE) write_pulse(0, r, item.write_data);
          else if (base == PULSE2_BASE) write_pulse(1, r, item.write_data);
          else if (base == SAW_BASE) write_saw(r, item.write_data);
        end
      end else begin
        tick_pulse(0);
        tick_pulse(1);
        tick_saw();
      end
      lv.pulse1_level = pulse_lvl[0];
      lv.pulse2_level = pulse_lvl[1];
      lv.saw_level    = saw_lvl;
      expected_levels.push_back(lv);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_levels(psc_out_t got);
      psc_out_t want;
      if (expected_levels.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_levels.pop_front();
        if (got.pulse1_level !== want.pulse1_level)
          report_mismatch($sformatf("pulse1_level got %0d expected %0d",
                                    got.pulse1_level, want.pulse1_level));
        if (got.pulse2_level !== want.pulse2_level)
          report_mismatch($sformatf("pulse2_level got %0d expected %0d",
                                    got.pulse2_level, want.pulse2_level));
        if (got.saw_level !== want.saw_level)
          report_mismatch($sformatf("saw_level got %0d expected %0d",
                                    got.saw_level, want.saw_level));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  psc_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  psc_out_t out_levels;

  tone_scoreboard sb = new();
  bit idle_allowed = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  pulse_sawtooth_sound_channels DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_levels)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic psc_in_t make_write(logic [15:0] addr, logic [7:0] d);
    psc_in_t it;
    it.mode = MODE_WRITE;
    it.address = addr;
    it.write_data = d;
    return it;
  endfunction

  function automatic psc_in_t make_tick();
    psc_in_t it;
    it.mode = MODE_TICK;
    it.address = 16'($urandom_range(0, 16'hFFFF));
    it.write_data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic psc_in_t random_item();
    logic [15:0] bases[3];
    logic [15:0] addr;
    logic [7:0]  d;
    bases[0] = PULSE1_BASE;
    bases[1] = PULSE2_BASE;
    bases[2] = SAW_BASE;
    if ($urandom_range(0, 99) < 72) return make_tick();
    if ($urandom_range(0, 9) == 0) begin
      addr = 16'($urandom_range(0, 16'hFFFF));
    end else begin
      addr = bases[$urandom_range(0, 2)] | 16'($urandom_range(0, 3));
    end
    d = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) begin
      // keep periods short and voices mostly enabled so steps happen often
      if (psc_reg_e'(addr[1:0]) == REG_PER_LO) begin
        d = 8'($urandom_range(0, 6));
      end else if (psc_reg_e'(addr[1:0]) == REG_PER_HI) begin
        d = {($urandom_range(0, 9) != 0), d[6:4], 4'h0};
      end
    end
    return make_write(addr, d);
  endfunction

  task automatic send_item(psc_in_t item);
    if (idle_allowed && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_item(item);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk);
  endtask

  // result side with random stall bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_levels(out_levels);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready <= 1'b1;
      end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 3);
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_tick());
    send_item(make_write(PULSE1_BASE | 16'(REG_PER_LO), 8'h01));
    send_item(make_write(PULSE1_BASE | 16'(REG_PER_HI), 8'h80));
    repeat (3) send_item(make_tick());
    send_item(make_write(PULSE1_BASE | 16'(REG_CTRL), 8'hFF));
    send_item(make_write(PULSE1_BASE | 16'(REG_CTRL), 8'h0A));
    repeat (2) send_item(make_tick());
    send_item(make_write(PULSE1_BASE | 16'(REG_NONE), 8'hFF));
    send_item(make_write(16'h0000, 8'hFF));
    send_item(make_write(16'hFFFF, 8'h00));
    send_item(make_write(PULSE2_BASE | 16'(REG_CTRL), 8'h5F));
    send_item(make_write(PULSE2_BASE | 16'(REG_PER_LO), 8'hFF));
    send_item(make_write(PULSE2_BASE | 16'(REG_PER_HI), 8'h8F));
    send_item(make_write(SAW_BASE | 16'(REG_CTRL), 8'hFF));
    send_item(make_write(SAW_BASE | 16'(REG_PER_LO), 8'h00));
    send_item(make_write(SAW_BASE | 16'(REG_PER_HI), 8'h80));
    send_item(make_tick());
    send_item(make_write(SAW_BASE | 16'(REG_PER_LO), 8'h01));
    repeat (4) send_item(make_tick());

    wait_drained();

    for (int i = 25; i < N_ITEMS; i++) begin
      if (i == N_ITEMS - CALM_ITEMS) idle_allowed = 1'b0;
      send_item(random_item());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_levels.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_levels.size()));
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
